// File: rtl/mic_pkg.sv
// ----------------------------------------------------------------------------
// mic_pkg: shared types and constants for the magnetometer calibration block
// Field widths, coefficient packing, register indexes and stage enables.
// ----------------------------------------------------------------------------
package mic_pkg;

  // Raw sample and offset width
  localparam int RAW_W      = 16;
  // Offset-corrected count width
  localparam int DIFF_W     = RAW_W + 1;
  // One soft-iron coefficient, and one packed row of three
  localparam int COEFF_W    = 18;
  localparam int ROW_W      = 3 * COEFF_W;
  // Single product and three-term row sum
  localparam int PROD_W     = COEFF_W + DIFF_W;
  localparam int SUM_W      = PROD_W + 2;
  // Calibrated field and temperature result widths
  localparam int CUT_W      = 32;
  localparam int TEMP_W     = 17;
  // 0.15 uT per count expressed in 0.01 uT units
  localparam int LSB_SCALE  = 15;
  // 25 C expressed in eighths of a degree
  localparam int TEMP_BIAS  = 200;
  // Register index width on the configuration port
  localparam int CFG_IDX_W  = 3;

  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X    = 3'd0,
    REG_OFFSET_Y    = 3'd1,
    REG_OFFSET_Z    = 3'd2,
    REG_MATRIX_ROW0 = 3'd3,
    REG_MATRIX_ROW1 = 3'd4,
    REG_MATRIX_ROW2 = 3'd5
  } reg_idx_e;

  // Load enables for the product, sum and output stages
  typedef struct packed {
    logic prod;
    logic sum;
    logic out;
  } stage_en_t;

endpackage

// File: rtl/mic_row.sv
// ----------------------------------------------------------------------------
// mic_row: one soft-iron matrix row
// Multiplies three corrected counts by one coefficient row, sums, rounds,
// scales by the LSB factor and saturates. Three register stages.
// ----------------------------------------------------------------------------
module mic_row #(
  parameter int FRAC_BITS = 14
) (
  input  logic                          clk_i,
  input  mic_pkg::stage_en_t            en_i,
  input  mic_pkg::diff_t                diff_i [3],
  input  logic [mic_pkg::ROW_W-1:0]     row_i,
  output logic signed [mic_pkg::CUT_W-1:0] cut_o
);
  import mic_pkg::*;

  localparam int CNT_W = SUM_W - FRAC_BITS;
  localparam int SCL_W = (CNT_W + 4 > CUT_W + 1) ? CNT_W + 4 : CUT_W + 1;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SCL_W-1:0] SAT_HI = SCL_W'(33'sh0_7FFF_FFFF);
  localparam logic signed [SCL_W-1:0] SAT_LO = SCL_W'(33'sh1_8000_0000);

  logic signed [PROD_W-1:0] prod_d [3];
  logic signed [PROD_W-1:0] prod_q [3];
  logic signed [SUM_W-1:0]  sum_d, sum_q;
  logic signed [CNT_W-1:0]  cnt;
  logic signed [SCL_W-1:0]  scaled;
  logic signed [CUT_W-1:0]  cut_d, cut_q;

  // Multiply each corrected count by its coefficient
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_d[c] = $signed(row_i[c*COEFF_W +: COEFF_W]) * diff_i[c];
    end
  end

  // Sum the row and add the rounding half
  assign sum_d = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2]) + RND;

  // Drop the fraction, times fifteen as sixteen minus one, clamp
  assign cnt    = sum_q[SUM_W-1:FRAC_BITS];
  assign scaled = (SCL_W'(cnt) <<< 4) - SCL_W'(cnt);

  always_comb begin
    priority if (scaled > SAT_HI) begin
      cut_d = SAT_HI[CUT_W-1:0];
    end else if (scaled < SAT_LO) begin
      cut_d = SAT_LO[CUT_W-1:0];
    end else begin
      cut_d = scaled[CUT_W-1:0];
    end
  end

  // Advance payload on each stage's load enable
  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      prod_q <= prod_d;
    end
    if (en_i.sum) begin
      sum_q <= sum_d;
    end
    if (en_i.out) begin
      cut_q <= cut_d;
    end
  end

  assign cut_o = cut_q;

endmodule

// File: rtl/magnetometer_iron_calibration.sv
// ----------------------------------------------------------------------------
// magnetometer_iron_calibration: hard/soft-iron correction of field samples
// Offset subtract, 3x3 matrix multiply, round, scale and temperature bias.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one raw sample per item; tdata holds x, y, z and
//   temperature counts, 16 bits each, x lowest. The master stream returns
//   one calibrated item per sample in the same order: x, y, z fields in
//   0.01 uT (32 bits each, saturated) and temperature in eighths of a degree.
//   The configuration port writes offsets and matrix rows by index; write
//   only while no sample is in flight. Unknown indexes are ignored.
//   An accepted sample passes the offset, multiply, row-sum and output stages
//   before output valid. Throughput without a stall is one item per cycle,
//   set by the fully pipelined multipliers (nine 18x17 products).
//   When the receiver stalls, items collect in the four stages and tready
//   drops only once every stage holds an item; nothing is lost or repeated.
//   Reset clears all stage valids and loads zero offsets and the identity
//   matrix; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module magnetometer_iron_calibration #(
  parameter int COEFF_FRAC_BITS = 14
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [mic_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [mic_pkg::ROW_W-1:0]        cfg_wdata_i,
  // Sample input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // fields from bit 0: field_x_raw, field_y_raw, field_z_raw, temp_raw
  input  logic [63:0]                      s_axis_tdata_i,
  // Calibrated output stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // fields from bit 0: field_x_cut, field_y_cut, field_z_cut, temp_eighths, zero pad
  output logic [119:0]                     m_axis_tdata_o
);
  import mic_pkg::*;

  localparam logic [ROW_W-1:0] ROW0_RST = ROW_W'(1) << (COEFF_FRAC_BITS);
  localparam logic [ROW_W-1:0] ROW1_RST = ROW_W'(1) << (COEFF_W + COEFF_FRAC_BITS);
  localparam logic [ROW_W-1:0] ROW2_RST = ROW_W'(1) << (2 * COEFF_W + COEFF_FRAC_BITS);

  logic signed [RAW_W-1:0] offset_q [3];
  logic [ROW_W-1:0]        row_q [3];

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  stage_en_t en;

  logic signed [RAW_W-1:0]  raw [3];
  logic signed [RAW_W-1:0]  temp_raw;
  diff_t                    diff_d [3];
  diff_t                    diff_q [3];
  logic signed [TEMP_W-1:0] temp_d;
  logic signed [TEMP_W-1:0] temp1_q, temp2_q, temp3_q, temp4_q;
  logic signed [CUT_W-1:0]  cut [3];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q[0] <= '0;
      offset_q[1] <= '0;
      offset_q[2] <= '0;
      row_q[0]    <= ROW0_RST;
      row_q[1]    <= ROW1_RST;
      row_q[2]    <= ROW2_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_OFFSET_X:    offset_q[0] <= cfg_wdata_i[RAW_W-1:0];
        REG_OFFSET_Y:    offset_q[1] <= cfg_wdata_i[RAW_W-1:0];
        REG_OFFSET_Z:    offset_q[2] <= cfg_wdata_i[RAW_W-1:0];
        REG_MATRIX_ROW0: row_q[0]    <= cfg_wdata_i;
        REG_MATRIX_ROW1: row_q[1]    <= cfg_wdata_i;
        REG_MATRIX_ROW2: row_q[2]    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage ready chain: a stage loads when empty or when it drains
  assign rdy4 = !v4_q || m_axis_tready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready_o = rdy1;

  assign en.prod = v1_q && rdy2;
  assign en.sum  = v2_q && rdy3;
  assign en.out  = v3_q && rdy4;

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Unpack the sample, subtract hard-iron offsets, bias temperature
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      raw[a]    = s_axis_tdata_i[a*RAW_W +: RAW_W];
      diff_d[a] = DIFF_W'(raw[a]) - DIFF_W'(offset_q[a]);
    end
    temp_raw = s_axis_tdata_i[3*RAW_W +: RAW_W];
    temp_d   = TEMP_W'(temp_raw) + TEMP_W'(TEMP_BIAS);
  end

  // Hold offset stage and carry temperature down the pipe
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && rdy1) begin
      diff_q  <= diff_d;
      temp1_q <= temp_d;
    end
    if (en.prod) temp2_q <= temp1_q;
    if (en.sum)  temp3_q <= temp2_q;
    if (en.out)  temp4_q <= temp3_q;
  end

  // One matrix row per axis
  for (genvar r = 0; r < 3; r++) begin : g_row
    mic_row #(
      .FRAC_BITS(COEFF_FRAC_BITS)
    ) u_row (
      .clk_i  (clk_i),
      .en_i   (en),
      .diff_i (diff_q),
      .row_i  (row_q[r]),
      .cut_o  (cut[r])
    );
  end

  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = {7'd0, temp4_q, cut[2], cut[1], cut[0]};

endmodule

// File: rtl/mic_checker.sv
// ----------------------------------------------------------------------------
// mic_checker: port-level checks for the magnetometer calibration block
// Output hold under stall, reset behavior, pipeline latency and temperature path.
// ----------------------------------------------------------------------------
module mic_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic [63:0]  s_axis_tdata_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [119:0] m_axis_tdata_o
);

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // Stalled output item stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped under stall");

  // Stalled output item keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output payload changed under stall");

  // No output item while in reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // With a free receiver an accepted item comes out of the output stage
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && m_axis_tready_i) ##1 m_axis_tready_i ##1 m_axis_tready_i
      ##1 m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("item missing after pipeline latency");

  // That item carries the biased temperature of the accepted sample
  a_temp_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && m_axis_tready_i) ##1 m_axis_tready_i ##1 m_axis_tready_i
      ##1 m_axis_tready_i |=>
      m_axis_tdata_o[112:96] ==
        17'($signed({$past(s_axis_tdata_i[63], 4), $past(s_axis_tdata_i[63:48], 4)})
            + 17'sd200))
    else $error("temperature result does not match sample");

endmodule

bind magnetometer_iron_calibration mic_checker u_mic_checker (.*);
